[sv/sfwi_pkg.sv]
// ----------------------------------------------------------------------------
// sfwi_pkg
// Shared types and constants for the step function window integrator.
// ----------------------------------------------------------------------------
package sfwi_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned ValueW = 32;
  localparam int unsigned SumW   = 64;
  localparam int unsigned DeltaW = TimeW + 1;
  localparam int unsigned AddrW  = 3;

  // Register index, taken from paddr[2]
  localparam logic RegWinStart = 1'b0;
  localparam logic RegWinEnd   = 1'b1;

  // Control that travels with one product to the accumulator stage
  typedef struct packed {
    logic add;    // add the product into the running sum
    logic emit;   // present the new sum as a result
    logic clear;  // zero the running sum afterwards (list finished)
  } sfwi_ctl_t;

endpackage

[sv/step_function_window_integrator.sv]
// ----------------------------------------------------------------------------
// step_function_window_integrator
// Integrates a sampled step function over a configured time window.
// ----------------------------------------------------------------------------
// Path: the input register loads at the request accept edge, then the product
//   register, then the accumulator and result register.
// Throughput: one request per cycle while the result stream takes results;
//   without back-pressure, requests stream back to back.
// Reset: clears window registers, held step state, running sum and all valids.
module step_function_window_integrator import sfwi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // sample stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,  // [31:0] sample_time, [63:32] sample_value
  input  logic              s_axis_tlast,  // end_of_list
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [63:0]       m_axis_tdata,  // [63:0] integral
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [TimeW-1:0] win_start_q, win_end_q;

  logic              in_valid_q;
  logic [TimeW-1:0]  in_time_q;
  logic [ValueW-1:0] in_value_q;
  logic              in_eol_q;

  logic              prod_valid_q;
  sfwi_ctl_t         prod_ctl_q;
  logic [SumW-1:0]   prod_q;

  logic [SumW-1:0]   sum_q, sum_d;
  logic              out_valid_q;
  logic [SumW-1:0]   out_data_q;

  sfwi_ctl_t         step_ctl;
  logic [SumW-1:0]   step_product;
  logic              out_free, acc_fire, acc_free, step_fire, in_fire;

  // Configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= '0;
      win_end_q   <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        RegWinStart: win_start_q <= pwdata;
        RegWinEnd:   win_end_q   <= pwdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegWinStart: prdata = win_start_q;
      RegWinEnd:   prdata = win_end_q;
      default:     prdata = '0;
    endcase
  end

  // Stage handshakes, from the output back
  assign out_free      = !out_valid_q || m_axis_tready;
  assign acc_fire      = prod_valid_q && (!prod_ctl_q.emit || out_free);
  assign acc_free      = !prod_valid_q || acc_fire;
  assign step_fire     = in_valid_q && acc_free;
  assign s_axis_tready = !in_valid_q || step_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_time_q  <= s_axis_tdata[TimeW-1:0];
      in_value_q <= s_axis_tdata[TimeW+ValueW-1:TimeW];
      in_eol_q   <= s_axis_tlast;
    end
  end

  // Decision and product
  sfwi_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (step_fire),
    .time_i      (in_time_q),
    .value_i     (in_value_q),
    .eol_i       (in_eol_q),
    .win_start_i (win_start_q),
    .win_end_i   (win_end_q),
    .ctl_o       (step_ctl),
    .product_o   (step_product)
  );

  // Product register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      prod_ctl_q   <= '0;
    end else if (acc_free) begin
      prod_valid_q <= step_fire;
      prod_ctl_q   <= step_ctl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      prod_q <= step_product;
    end
  end

  // Accumulate; zero the sum when the list finishes
  assign sum_d = prod_ctl_q.add ? (sum_q + prod_q) : sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (acc_fire) begin
      sum_q <= prod_ctl_q.clear ? '0 : sum_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= acc_fire && prod_ctl_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_fire && prod_ctl_q.emit) begin
      out_data_q <= sum_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  a_emit_adds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_valid_q && prod_ctl_q.emit |-> prod_ctl_q.add)
    else $error("result without accumulate");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_fire && prod_ctl_q.clear |=> sum_q == '0)
    else $error("sum not cleared at end of list");

  a_rose_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(acc_fire && prod_ctl_q.emit))
    else $error("result valid without emitting request");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("empty input stage not ready");

endmodule

[sv/sfwi_step.sv]
// ----------------------------------------------------------------------------
// sfwi_step
// Per-request decision and product: holds the step function state and forms
// (upto - from) * held_value for the accumulator stage.
// ----------------------------------------------------------------------------
module sfwi_step import sfwi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [TimeW-1:0]   time_i,
  input  logic [ValueW-1:0]  value_i,
  input  logic               eol_i,
  input  logic [TimeW-1:0]   win_start_i,
  input  logic [TimeW-1:0]   win_end_i,
  output sfwi_ctl_t          ctl_o,
  output logic [SumW-1:0]    product_o
);

  logic [ValueW-1:0] held_value_q, held_value_d;
  logic [TimeW-1:0]  held_time_q, held_time_d;
  logic              latched_q, latched_d;
  logic              closed_q, closed_d;

  logic [TimeW-1:0]       from_time;
  logic [TimeW-1:0]       upto_time;
  logic                   after_start;
  logic                   past_end;
  logic                   at_end;
  logic [DeltaW-1:0]      delta;
  logic signed [SumW-1:0] prod_full;

  // Window compares and the piece to add
  assign from_time   = latched_q ? held_time_q : win_start_i;
  assign after_start = time_i > win_start_i;
  assign past_end    = time_i > win_end_i;
  assign at_end      = time_i >= win_end_i;
  assign upto_time   = (eol_i || past_end) ? win_end_i : time_i;
  assign delta       = {1'b0, upto_time} - {1'b0, from_time};
  assign prod_full   = $signed(delta) * $signed(held_value_q);
  assign product_o   = prod_full;

  // Decide what the accumulator does with this request
  always_comb begin
    ctl_o.clear = eol_i;
    if (eol_i) begin
      ctl_o.add  = !closed_q;
      ctl_o.emit = !closed_q;
    end else begin
      ctl_o.add  = !closed_q && after_start;
      ctl_o.emit = !closed_q && after_start && at_end;
    end
  end

  // Next state of the held step
  always_comb begin
    held_value_d = held_value_q;
    held_time_d  = held_time_q;
    latched_d    = latched_q;
    closed_d     = closed_q;
    if (eol_i) begin
      held_value_d = '0;
      held_time_d  = '0;
      latched_d    = 1'b0;
      closed_d     = 1'b0;
    end else if (!closed_q) begin
      if (after_start && at_end) begin
        closed_d = 1'b1;
      end else begin
        held_value_d = value_i;
        if (after_start) begin
          held_time_d = time_i;
          latched_d   = 1'b1;
        end
      end
    end
  end

  // Advance state on each request taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_value_q <= '0;
      held_time_q  <= '0;
      latched_q    <= 1'b0;
      closed_q     <= 1'b0;
    end else if (fire_i) begin
      held_value_q <= held_value_d;
      held_time_q  <= held_time_d;
      latched_q    <= latched_d;
      closed_q     <= closed_d;
    end
  end

endmodule

[sim/tb_step_function_window_integrator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_step_function_window_integrator
// Checks the integral of a sampled step function over a programmed window.
// Directed requests hit the window edges, closed runs and field extremes.
// Random runs of ordered samples follow, mixed with noise and out-of-order
// times, over several window settings and stall patterns. A scoreboard
// predicts each integral and compares it with the result stream in order.
// ----------------------------------------------------------------------------
module tb_step_function_window_integrator import sfwi_pkg::*; ();

  localparam int unsigned PipeLat  = 3;
  localparam int unsigned LongHold = 300;

  // Predict integrals from accepted sample requests and hold them in order
  class integral_scoreboard;
    bit [31:0]        win_start;
    bit [31:0]        win_end;
    bit signed [31:0] held_value;
    bit [31:0]        held_time;
    bit               time_latched;
    bit               run_closed;
    bit [63:0]        running_sum;
    bit [63:0]        expected_integrals[$];
    int unsigned      mismatches;
    int unsigned      integrals_checked;
    int unsigned      samples_seen;

    function void set_register(logic idx, bit [31:0] value);
      if (idx == RegWinStart) begin
        win_start = value;
      end else begin
        win_end = value;
      end
    endfunction

    function void restart();
      held_value   = '0;
      held_time    = '0;
      time_latched = 1'b0;
      running_sum  = '0;
      run_closed   = 1'b0;
    endfunction

    // (t1 - t0) * v, wrapping at 64 bits
    function bit [63:0] area(bit [31:0] t1, bit [31:0] t0, bit signed [31:0] v);
      bit signed [63:0] span;
      bit signed [63:0] level;
      span  = $signed({32'd0, t1}) - $signed({32'd0, t0});
      level = v;
      return span * level;
    endfunction

    function void note_sample(bit [31:0] t, bit signed [31:0] v, bit eol);
      bit [31:0] from;
      bit [31:0] upto;
      samples_seen++;
      from = time_latched ? held_time : win_start;
      if (eol) begin
        // close an open run, then start over
        if (!run_closed) begin
          running_sum += area(win_end, from, held_value);
          expected_integrals.push_back(running_sum);
        end
        restart();
        return;
      end
      if (run_closed) return;
      if (t > win_start) begin
        upto = (t > win_end) ? win_end : t;
        running_sum += area(upto, from, held_value);
        if (t >= win_end) begin
          run_closed = 1'b1;
          expected_integrals.push_back(running_sum);
          return;
        end
        held_time    = t;
        time_latched = 1'b1;
      end
      held_value = v;
    endfunction

    function void check_integral(bit [63:0] got);
      bit [63:0] want;
      if (expected_integrals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected integral %h at %0t", got, $realtime);
        return;
      end
      want = expected_integrals.pop_front();
      integrals_checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: integral expected %h got %h at %0t", want, got, $realtime);
      end
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata  = '0;
  logic              s_axis_tlast  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [63:0]       m_axis_tdata;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [AddrW-1:0]  paddr         = '0;
  logic [31:0]       pwdata        = '0;
  logic [31:0]       prdata;
  logic              pready;

  integral_scoreboard sb = new();

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_reqs    = 0;
  int unsigned holds_seen   = 0;
  int unsigned hold_left    = 0;
  int unsigned windows_used = 0;

  step_function_window_integrator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] sample_time, [63:32] sample_value
    .s_axis_tlast  (s_axis_tlast),   // end_of_list
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [63:0] integral
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  // Check results and drive ready, with random stalls and long hold-offs
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_integral(m_axis_tdata);
    if (hold_reqs != holds_seen) begin
      holds_seen = hold_reqs;
      hold_left  = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Offer one sample request, with random idle cycles ahead of it
  task automatic send_sample(bit [31:0] t, bit [31:0] v, bit eol);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, t};
    s_axis_tlast  <= eol;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(t, v, eol);
  endtask

  // Hold the sender until every predicted integral has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_integrals.size() != 0) @(posedge clk_i);
    repeat (PipeLat + 3) @(posedge clk_i);
  endtask

  task automatic apb_write(logic idx, bit [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
  endtask

  task automatic set_window(bit [31:0] ws, bit [31:0] we);
    apb_write(RegWinStart, ws);
    apb_write(RegWinEnd, we);
    windows_used++;
  endtask

  function automatic bit [31:0] rand_level();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Send one list of samples around the window, mostly in order, then end the list
  task automatic send_run();
    bit [31:0] lo;
    bit [31:0] hi;
    bit [31:0] a;
    bit [31:0] b;
    bit [31:0] tmp;
    bit [31:0] times[$];
    int        n;
    int        k;
    a  = (sb.win_start < sb.win_end) ? sb.win_start : sb.win_end;
    b  = (sb.win_start < sb.win_end) ? sb.win_end : sb.win_start;
    lo = (a > 1000) ? a - $urandom_range(1000) : 32'd0;
    hi = (b < 32'hFFFF_FC00) ? b + $urandom_range(1000) : 32'hFFFF_FFFF;
    n  = $urandom_range(1, 7);
    for (int i = 0; i < n; i++) times.push_back($urandom_range(hi, lo));
    if ($urandom_range(3) == 0) times.push_back(sb.win_start);
    if ($urandom_range(3) == 0) times.push_back(sb.win_end);
    times.sort();
    // swap a neighbor pair now and then to break the ordering
    if ($urandom_range(9) == 0 && times.size() > 1) begin
      k            = $urandom_range(times.size() - 2);
      tmp          = times[k];
      times[k]     = times[k + 1];
      times[k + 1] = tmp;
    end
    foreach (times[i]) send_sample(times[i], rand_level(), 1'b0);
    send_sample($urandom, $urandom, 1'b1);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) send_sample($urandom, $urandom, $urandom_range(2) == 0);
  endtask

  initial begin
    int unsigned target;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: window edges, closed runs, order and field extremes
    set_window(32'd10, 32'd20);
    send_sample(32'd5, 32'd7, 1'b0);            // before start: latch only
    send_sample(32'd10, -32'sd3, 1'b0);         // exactly at start
    send_sample(32'd12, 32'h7FFF_FFFF, 1'b0);   // inside
    send_sample(32'd15, 32'h8000_0000, 1'b0);
    send_sample(32'd20, 32'd1, 1'b0);           // exactly at end: close
    send_sample(32'd25, 32'd9, 1'b0);           // ignored after close
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);  // end of list, closed
    send_sample(32'd11, 32'd4, 1'b0);
    send_sample(32'd0, 32'd0, 1'b1);            // end of list, run open
    send_sample(32'd30, 32'd5, 1'b0);           // past end with nothing held
    send_sample(32'd0, 32'd0, 1'b1);
    send_sample(32'd0, 32'd0, 1'b1);            // empty list
    send_sample(32'd14, 32'd6, 1'b0);
    send_sample(32'd12, 32'hFFFF_FFFF, 1'b0);   // time goes backward
    send_sample(32'hFFFF_FFFF, 32'd3, 1'b0);    // past end
    send_sample(32'd7, 32'd7, 1'b1);
    drain();
    set_window(32'd0, 32'hFFFF_FFFF);
    send_sample(32'd0, 32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 32'd0, 1'b0);
    send_sample(32'd0, 32'd0, 1'b1);
    drain();
    set_window(32'd50, 32'd10);                 // end below start
    send_sample(32'd5, 32'd9, 1'b0);
    send_sample(32'd30, 32'd2, 1'b0);
    send_sample(32'd0, 32'd0, 1'b1);

    // Random runs over several windows and stall patterns
    target = sb.samples_seen;
    for (int p = 0; p < 8; p++) begin
      drain();
      case (p % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 78; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 78; end
        default: begin tx_idle_pct = 6;  rx_stall_pct = 6;  end
      endcase
      case (p)
        0: set_window(32'd1000, 32'd1100);
        1: set_window(32'd0, 32'hFFFF_FFFF);
        2: set_window(32'hFFFF_FFF0, 32'hFFFF_FFFF);
        3: set_window(32'd5000, 32'd100);
        4: set_window(32'd0, 32'd0);
        5: set_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        6: set_window(32'd200_000, 32'd200_000 + $urandom_range(5000));
        default: set_window($urandom, $urandom);
      endcase
      // stall the result side for a long stretch while requests keep coming
      if (p == 0) hold_reqs++;
      target += 65;
      while (sb.samples_seen < target) begin
        if ($urandom_range(39) == 0) drain();
        if ($urandom_range(6) == 0) begin
          send_noise();
        end else begin
          send_run();
        end
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("Run covered %0d sample requests over %0d window settings,",
             sb.samples_seen, windows_used);
    $display("with %0d integrals checked and %0d left unanswered.",
             sb.integrals_checked, sb.expected_integrals.size());
    if (sb.mismatches == 0 && sb.expected_integrals.size() == 0) begin
      $display("step_function_window_integrator test passed");
    end else begin
      $display("Mismatches: %0d", sb.mismatches);
      $display("step_function_window_integrator test failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("Timeout with %0d integrals outstanding", sb.expected_integrals.size());
    $display("step_function_window_integrator test failed");
    $finish;
  end

endmodule
